// File: rtl/core/atstd_pkg.sv
package atstd_pkg;

    localparam int unsigned AXIS_W  = 16;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned JERK_W  = 18;
    localparam int unsigned SIDE_W  = 15;
    localparam int unsigned HOLD_W  = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 18;

    // Gap required between the last shake and a tap.
    localparam logic [TIME_W-1:0] TAP_AFTER_SHAKE_MS = 32'd1000;

    // Register reset values (0.45 g, 0.78 g, 1.40 g, 0.50 g, 1.6 g at 4096 LSB/g).
    localparam logic [SIDE_W-1:0] TILT_SIDE_RST  = 15'd1843;
    localparam logic [SIDE_W-1:0] FLAT_Z_RST     = 15'd3195;
    localparam logic [JERK_W-1:0] SHAKE_JERK_RST = 18'd5734;
    localparam logic [JERK_W-1:0] TAP_LOW_RST    = 18'd2048;
    localparam logic [JERK_W-1:0] TAP_HIGH_RST   = 18'd6554;
    localparam logic [HOLD_W-1:0] TILT_HOLD_RST  = 16'd700;
    localparam logic [HOLD_W-1:0] SHAKE_HOLD_RST = 16'd2000;
    localparam logic [HOLD_W-1:0] TAP_HOLD_RST   = 16'd500;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TILT_SIDE_LIMIT  = 3'd0,
        REG_FLAT_Z_LIMIT     = 3'd1,
        REG_SHAKE_JERK_LIMIT = 3'd2,
        REG_TAP_JERK_LOW     = 3'd3,
        REG_TAP_JERK_HIGH    = 3'd4,
        REG_TILT_HOLDOFF     = 3'd5,
        REG_SHAKE_HOLDOFF    = 3'd6,
        REG_TAP_HOLDOFF      = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [SIDE_W-1:0] tilt_side_limit;
        logic [SIDE_W-1:0] flat_z_limit;
        logic [JERK_W-1:0] shake_jerk_limit;
        logic [JERK_W-1:0] tap_jerk_low;
        logic [JERK_W-1:0] tap_jerk_high;
        logic [HOLD_W-1:0] tilt_holdoff_ms;
        logic [HOLD_W-1:0] shake_holdoff_ms;
        logic [HOLD_W-1:0] tap_holdoff_ms;
    } cfg_t;

    typedef struct packed {
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
        logic [TIME_W-1:0]        sample_time_ms;
        logic                     sample_ok;
    } sample_t;

    typedef struct packed {
        logic              tilt_event;
        logic              shake_event;
        logic              tap_event;
        logic [JERK_W-1:0] jerk_value;
    } result_t;

    // Magnitude of a 17-bit signed value known to lie within +/-65535.
    function automatic logic [AXIS_W-1:0] mag17(logic signed [AXIS_W:0] v);
        logic signed [AXIS_W:0] neg;
        neg = -v;
        return v[AXIS_W] ? neg[AXIS_W-1:0] : v[AXIS_W-1:0];
    endfunction

endpackage

// File: rtl/core/atstd_sample_if.sv
interface atstd_sample_if;
    logic                valid;
    logic                ready;
    atstd_pkg::sample_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/atstd_result_if.sv
interface atstd_result_if;
    logic                valid;
    logic                ready;
    atstd_pkg::result_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/atstd_cfg_regs.sv
module atstd_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [atstd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [atstd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output atstd_pkg::cfg_t                      cfg
);

    atstd_pkg::cfg_t cfg_reg;
    atstd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (atstd_pkg::cfg_index_t'(cfg_index))
                atstd_pkg::REG_TILT_SIDE_LIMIT:
                    cfg_next.tilt_side_limit = cfg_wdata[atstd_pkg::SIDE_W-1:0];
                atstd_pkg::REG_FLAT_Z_LIMIT:
                    cfg_next.flat_z_limit = cfg_wdata[atstd_pkg::SIDE_W-1:0];
                atstd_pkg::REG_SHAKE_JERK_LIMIT:
                    cfg_next.shake_jerk_limit = cfg_wdata[atstd_pkg::JERK_W-1:0];
                atstd_pkg::REG_TAP_JERK_LOW:
                    cfg_next.tap_jerk_low = cfg_wdata[atstd_pkg::JERK_W-1:0];
                atstd_pkg::REG_TAP_JERK_HIGH:
                    cfg_next.tap_jerk_high = cfg_wdata[atstd_pkg::JERK_W-1:0];
                atstd_pkg::REG_TILT_HOLDOFF:
                    cfg_next.tilt_holdoff_ms = cfg_wdata[atstd_pkg::HOLD_W-1:0];
                atstd_pkg::REG_SHAKE_HOLDOFF:
                    cfg_next.shake_holdoff_ms = cfg_wdata[atstd_pkg::HOLD_W-1:0];
                atstd_pkg::REG_TAP_HOLDOFF:
                    cfg_next.tap_holdoff_ms = cfg_wdata[atstd_pkg::HOLD_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tilt_side_limit  <= atstd_pkg::TILT_SIDE_RST;
            cfg_reg.flat_z_limit     <= atstd_pkg::FLAT_Z_RST;
            cfg_reg.shake_jerk_limit <= atstd_pkg::SHAKE_JERK_RST;
            cfg_reg.tap_jerk_low     <= atstd_pkg::TAP_LOW_RST;
            cfg_reg.tap_jerk_high    <= atstd_pkg::TAP_HIGH_RST;
            cfg_reg.tilt_holdoff_ms  <= atstd_pkg::TILT_HOLD_RST;
            cfg_reg.shake_holdoff_ms <= atstd_pkg::SHAKE_HOLD_RST;
            cfg_reg.tap_holdoff_ms   <= atstd_pkg::TAP_HOLD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/atstd_eval.sv
module atstd_eval
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  atstd_pkg::sample_t  item,
    input  atstd_pkg::cfg_t     cfg,
    output atstd_pkg::result_t  res
);

    localparam int unsigned AW = atstd_pkg::AXIS_W;
    localparam int unsigned TW = atstd_pkg::TIME_W;
    localparam int unsigned JW = atstd_pkg::JERK_W;

    logic                 have_prev_reg, have_prev_next;
    logic signed [AW-1:0] prev_x_reg, prev_x_next;
    logic signed [AW-1:0] prev_y_reg, prev_y_next;
    logic signed [AW-1:0] prev_z_reg, prev_z_next;
    logic [TW-1:0]        last_tilt_reg, last_tilt_next;
    logic [TW-1:0]        last_shake_reg, last_shake_next;
    logic [TW-1:0]        last_tap_reg, last_tap_next;

    logic signed [AW:0] dx, dy, dz;
    logic [AW-1:0]      ax, ay, az;
    logic [JW-1:0]      jerk_sum, jerk;
    logic [TW-1:0]      dt_tilt, dt_shake, dt_tap;
    logic               tilt_hit, shake_hit, tap_hit, ok;

    // Differences in 17 bits so full-scale swings do not wrap.
    assign dx = {item.accel_x[AW-1], item.accel_x} - {prev_x_reg[AW-1], prev_x_reg};
    assign dy = {item.accel_y[AW-1], item.accel_y} - {prev_y_reg[AW-1], prev_y_reg};
    assign dz = {item.accel_z[AW-1], item.accel_z} - {prev_z_reg[AW-1], prev_z_reg};

    assign jerk_sum = JW'(atstd_pkg::mag17(dx)) + JW'(atstd_pkg::mag17(dy))
                    + JW'(atstd_pkg::mag17(dz));

    assign ax = atstd_pkg::mag17({item.accel_x[AW-1], item.accel_x});
    assign ay = atstd_pkg::mag17({item.accel_y[AW-1], item.accel_y});
    assign az = atstd_pkg::mag17({item.accel_z[AW-1], item.accel_z});

    assign ok   = item.sample_ok;
    assign jerk = (ok && have_prev_reg) ? jerk_sum : '0;

    // Wrapping elapsed time since each event.
    assign dt_tilt  = item.sample_time_ms - last_tilt_reg;
    assign dt_shake = item.sample_time_ms - last_shake_reg;
    assign dt_tap   = item.sample_time_ms - last_tap_reg;

    assign tilt_hit = ok
                   && (ax > AW'(cfg.tilt_side_limit) || ay > AW'(cfg.tilt_side_limit)
                       || az < AW'(cfg.flat_z_limit))
                   && dt_tilt > TW'(cfg.tilt_holdoff_ms);

    assign shake_hit = ok && jerk > cfg.shake_jerk_limit
                    && dt_shake > TW'(cfg.shake_holdoff_ms);

    // A shake in this sample blocks a tap, as does any shake within the last TAP_AFTER_SHAKE_MS.
    assign tap_hit = ok && jerk > cfg.tap_jerk_low && jerk < cfg.tap_jerk_high
                  && dt_tap > TW'(cfg.tap_holdoff_ms)
                  && !shake_hit && dt_shake > atstd_pkg::TAP_AFTER_SHAKE_MS;

    always_comb
    begin
        res.tilt_event  = tilt_hit;
        res.shake_event = shake_hit;
        res.tap_event   = tap_hit;
        res.jerk_value  = jerk;
    end

    always_comb
    begin
        have_prev_next  = have_prev_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        prev_z_next     = prev_z_reg;
        last_tilt_next  = last_tilt_reg;
        last_shake_next = last_shake_reg;
        last_tap_next   = last_tap_reg;
        if (step && ok)
        begin
            have_prev_next = 1'b1;
            prev_x_next    = item.accel_x;
            prev_y_next    = item.accel_y;
            prev_z_next    = item.accel_z;
            if (tilt_hit)
            begin
                last_tilt_next = item.sample_time_ms;
            end
            if (shake_hit)
            begin
                last_shake_next = item.sample_time_ms;
            end
            if (tap_hit)
            begin
                last_tap_next = item.sample_time_ms;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg  <= 1'b0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_z_reg     <= '0;
            last_tilt_reg  <= '0;
            last_shake_reg <= '0;
            last_tap_reg   <= '0;
        end
        else
        begin
            have_prev_reg  <= have_prev_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            prev_z_reg     <= prev_z_next;
            last_tilt_reg  <= last_tilt_next;
            last_shake_reg <= last_shake_next;
            last_tap_reg   <= last_tap_next;
        end
    end

endmodule

// File: rtl/core/accel_tilt_shake_tap_detector_top.sv
// Path: an accepted sample is held in the input register, then its result is loaded
//   into the result register that drives the output port; a stalled receiver holds the
//   result register and so delays that load.
// Throughput: one sample per cycle, set by the combinational compare/add path into the
//   result register; a waiting result stalls new samples only once the input stage is full.
// Reset: rst_n clears valids, history and event times and loads the default thresholds.
module accel_tilt_shake_tap_detector_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    atstd_sample_if.sink                      sample,
    atstd_result_if.source                    result,
    input  logic                              cfg_we,
    input  logic [atstd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [atstd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    atstd_pkg::cfg_t     cfg;
    atstd_pkg::result_t  eval_res;

    // Input stage: holds one accepted sample until the result register can take it.
    logic                in_vld_reg, in_vld_next;
    atstd_pkg::sample_t  in_item_reg;

    // Output stage: the result presented on the result channel.
    logic                out_vld_reg, out_vld_next;
    atstd_pkg::result_t  out_item_reg;

    logic out_load;   // result register free or being drained this cycle
    logic step;       // input stage evaluates and moves into the result register
    logic take;       // sample transfer this cycle

    atstd_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // History (previous sample, event times) updates only when a sample with sample_ok set
    // leaves the input stage, so samples see state in arrival order.
    atstd_eval u_eval
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (eval_res)
    );

    assign out_load     = !out_vld_reg || result.ready;
    assign step         = in_vld_reg && out_load;
    assign sample.ready = !in_vld_reg || out_load;
    assign take         = sample.valid && sample.ready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (take)
        begin
            in_vld_next = 1'b1;
        end
        else if (step)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (out_load)
        begin
            out_vld_next = in_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg <= sample.payload;
        end
        if (step)
        begin
            out_item_reg <= eval_res;
        end
    end

    assign result.valid   = out_vld_reg;
    assign result.payload = out_item_reg;

endmodule
